@@ hw/rtl/atpb_pkg.sv @@
// ----------------------------------------------------------------------------
// atpb_pkg
// shared constants, types and tone tables for the alert table priority buzzer
// ----------------------------------------------------------------------------
package atpb_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HELD_W      = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (HELD_W > 3) ? HELD_W : 3;

  // configuration port
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_BUZZER_ENABLE  = 2'd0;
  localparam logic [1:0] REG_DEDUP_WINDOW   = 2'd1;
  localparam logic [1:0] REG_REPEAT_INTERVAL = 2'd2;

  localparam logic        RST_BUZZER_ENABLE   = 1'b1;
  localparam logic [15:0] RST_DEDUP_WINDOW    = 16'd30000;
  localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd2000;

  // alert type codes, larger value wins on a tick
  localparam logic [2:0] ALERT_BLANK    = 3'd0;
  localparam logic [2:0] ALERT_HIGH_HR  = 3'd1;
  localparam logic [2:0] ALERT_LOW_HR   = 3'd2;
  localparam logic [2:0] ALERT_DESAT    = 3'd3;
  localparam logic [2:0] ALERT_BATTERY  = 3'd4;
  localparam logic [2:0] ALERT_SENSOR   = 3'd5;
  localparam logic [2:0] ALERT_SPARE_6  = 3'd6;
  localparam logic [2:0] ALERT_SPARE_7  = 3'd7;

  typedef enum logic [2:0] {
    MODE_ADD,
    MODE_ACK,
    MODE_CLEAR,
    MODE_TICK,
    MODE_READ
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic        buzzer_enable;
    logic [15:0] dedup_window_ms;
    logic [15:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] stamp;
    logic        acked;
  } slot_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

  function automatic logic [10:0] tone_freq(input logic [2:0] kind);
    logic [10:0] f;
    unique case (kind)
      ALERT_HIGH_HR, ALERT_DESAT: f = 11'd1000;
      ALERT_LOW_HR:               f = 11'd800;
      ALERT_BATTERY:              f = 11'd600;
      ALERT_SENSOR:               f = 11'd1200;
      default:                    f = 11'd0;
    endcase
    return f;
  endfunction

  function automatic logic [8:0] tone_len(input logic [2:0] kind);
    logic [8:0] l;
    unique case (kind)
      ALERT_HIGH_HR, ALERT_DESAT: l = 9'd200;
      ALERT_LOW_HR:               l = 9'd300;
      ALERT_BATTERY:              l = 9'd100;
      ALERT_SENSOR:               l = 9'd150;
      default:                    l = 9'd0;
    endcase
    return l;
  endfunction

  function automatic logic [2:0] tone_pulses(input logic [2:0] kind);
    logic [2:0] p;
    unique case (kind)
      ALERT_HIGH_HR, ALERT_DESAT: p = 3'd3;
      ALERT_LOW_HR:               p = 3'd2;
      ALERT_BATTERY:              p = 3'd1;
      ALERT_SENSOR:               p = 3'd4;
      default:                    p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/atpb_if.sv @@
// ----------------------------------------------------------------------------
// atpb_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface atpb_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [2:0]  alert_type;
  logic [2:0]  entry_index;
  logic [31:0] now_ms;

  modport source (output valid, mode, alert_type, entry_index, now_ms, input ready);
  modport sink   (input valid, mode, alert_type, entry_index, now_ms, output ready);
endinterface

interface atpb_out_if;
  logic        valid;
  logic        ready;
  logic        tone_start;
  logic [10:0] tone_freq_hz;
  logic [8:0]  tone_len_ms;
  logic [2:0]  tone_pulses;
  logic        any_active;
  logic [3:0]  stored_count;
  logic [2:0]  read_type;
  logic [31:0] read_time;
  logic        read_acked;

  modport source (output valid, tone_start, tone_freq_hz, tone_len_ms, tone_pulses,
                  any_active, stored_count, read_type, read_time, read_acked,
                  input ready);
  modport sink   (input valid, tone_start, tone_freq_hz, tone_len_ms, tone_pulses,
                  any_active, stored_count, read_type, read_time, read_acked,
                  output ready);
endinterface

@@ hw/rtl/atpb_ctrl.sv @@
// ----------------------------------------------------------------------------
// atpb_ctrl
// sequencer: accept a beat, scan the held slots, commit and load the result
// ----------------------------------------------------------------------------
module atpb_ctrl import atpb_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          state_next = ST_COMMIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_COMMIT: begin
        // wait here while the previous result is still unclaimed
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/atpb_datapath.sv @@
// ----------------------------------------------------------------------------
// atpb_datapath
// alert slots, scan accumulators, table update and result register
// ----------------------------------------------------------------------------
module atpb_datapath import atpb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  cfg_t        cfg,
  input  logic [2:0]  mode,
  input  logic [2:0]  alert_type,
  input  logic [2:0]  entry_index,
  input  logic [31:0] now_ms,
  atpb_out_if.source  rsp
);

  // latched item
  logic [2:0]  mode_q;
  logic [2:0]  type_q;
  logic [2:0]  idx_q;
  logic [31:0] now_q;

  // table state
  slot_t             slots [TABLE_DEPTH];
  logic [HELD_W-1:0] held_count;
  logic [31:0]       last_tone_time;

  // scan accumulators
  logic [HELD_W-1:0] cnt;
  logic              dup;
  logic              pre_active;
  logic              active_excl;
  logic [2:0]        best;
  logic [2:0]        rd_type;
  logic [31:0]       rd_time;
  logic              rd_acked;

  // result register
  logic out_valid;

  slot_t             cur;
  slot_t             new_slot;
  logic [31:0]       age_cur;
  logic [31:0]       tick_age;
  logic              cnt_is_idx;
  logic              idx_in_range;
  logic              is_full;
  logic              do_append;
  logic              do_ack;
  logic              do_tick;
  logic              tone_on;
  logic [2:0]        tone_kind;
  logic              active_next;
  logic [HELD_W-1:0] held_next;

  assign cur          = slots[cnt[IDX_W-1:0]];
  assign age_cur      = now_q - cur.stamp;
  assign tick_age     = now_q - last_tone_time;
  assign cnt_is_idx   = (CMP_W'(cnt) == CMP_W'(idx_q));
  assign idx_in_range = (CMP_W'(idx_q) < CMP_W'(held_count));
  assign is_full      = (held_count == HELD_W'(TABLE_DEPTH));
  assign new_slot     = '{kind: type_q, stamp: now_q, acked: 1'b0};

  assign do_append = (mode_q == MODE_ADD) && !dup;
  assign do_ack    = (mode_q == MODE_ACK) && idx_in_range;
  assign do_tick   = (mode_q == MODE_TICK) && cfg.buzzer_enable && pre_active &&
                     (tick_age > {16'd0, cfg.repeat_interval_ms}) && (best != ALERT_BLANK);
  assign tone_kind = do_tick ? best : type_q;
  assign tone_on   = ((do_append && cfg.buzzer_enable) || do_tick) &&
                     (tone_pulses(tone_kind) != 3'd0);

  always_comb begin
    held_next   = held_count;
    active_next = pre_active;
    if (do_append) begin
      active_next = 1'b1;
      if (!is_full) begin
        held_next = held_count + HELD_W'(1);
      end
    end else if (mode_q == MODE_ACK) begin
      active_next = active_excl;
    end else if (mode_q == MODE_CLEAR) begin
      held_next   = '0;
      active_next = 1'b0;
    end
  end

  assign status.scan_done = (cnt == held_count);
  assign status.out_free  = !out_valid || rsp.ready;

  // item latch and scan, one slot per cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q      <= mode;
      type_q      <= alert_type;
      idx_q       <= entry_index;
      now_q       <= now_ms;
      cnt         <= '0;
      dup         <= 1'b0;
      pre_active  <= 1'b0;
      active_excl <= 1'b0;
      best        <= ALERT_BLANK;
      rd_type     <= 3'd0;
      rd_time     <= 32'd0;
      rd_acked    <= 1'b0;
    end else if (cmd.step) begin
      cnt <= cnt + HELD_W'(1);
      if ((cur.kind == type_q) && (age_cur < {16'd0, cfg.dedup_window_ms})) begin
        dup <= 1'b1;
      end
      if (!cur.acked) begin
        pre_active <= 1'b1;
        if (cur.kind > best) begin
          best <= cur.kind;
        end
        // the slot being acknowledged no longer counts as active
        if (!((mode_q == MODE_ACK) && cnt_is_idx)) begin
          active_excl <= 1'b1;
        end
      end
      if ((mode_q == MODE_READ) && cnt_is_idx) begin
        rd_type  <= cur.kind;
        rd_time  <= cur.stamp;
        rd_acked <= cur.acked;
      end
    end
  end

  // slot updates: shift out the oldest when full, append, acknowledge
  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        if (do_append && is_full) begin
          if (j < TABLE_DEPTH - 1) begin
            slots[j] <= slots[(j + 1) % TABLE_DEPTH];
          end else begin
            slots[j] <= new_slot;
          end
        end else if (do_append && (HELD_W'(j) == held_count)) begin
          slots[j] <= new_slot;
        end else if (do_ack && (CMP_W'(j) == CMP_W'(idx_q))) begin
          slots[j].acked <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count     <= '0;
      last_tone_time <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.commit) begin
        held_count <= held_next;
        if (do_tick) begin
          last_tone_time <= now_q;
        end
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.tone_start   <= tone_on;
      rsp.tone_freq_hz <= tone_on ? tone_freq(tone_kind) : 11'd0;
      rsp.tone_len_ms  <= tone_on ? tone_len(tone_kind) : 9'd0;
      rsp.tone_pulses  <= tone_on ? tone_pulses(tone_kind) : 3'd0;
      rsp.any_active   <= active_next;
      rsp.stored_count <= 4'(held_next);
      rsp.read_type    <= rd_type;
      rsp.read_time    <= rd_time;
      rsp.read_acked   <= rd_acked;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ hw/rtl/alert_table_priority_buzzer.sv @@
// ----------------------------------------------------------------------------
// alert_table_priority_buzzer
// alert table with deduplication, acknowledge and priority tone repeat
// ----------------------------------------------------------------------------
// usage
//   req carries one command beat: mode (add, acknowledge, clear, tick, read),
//   alert_type, entry_index and the current time now_ms
//   rsp returns exactly one result beat per request beat, in order: tone
//   fields, any_active, stored_count and the read fields
//   the apb port writes buzzer_enable (0x0), dedup_window_ms (0x4) and
//   repeat_interval_ms (0x8); write only while no request is in flight
// timing
//   a request is accepted in the idle state; the n slots held when it arrives
//   are then scanned one slot per cycle through a single slot read port; at
//   commit the result is loaded into the result register and the block
//   returns to idle, so it takes no new request until the last one commits
// reset
//   rst (synchronous) empties the table, zeroes the last tone time, drops any
//   pending result and loads the register reset values
// backpressure
//   the result register holds its beat while rsp.ready is low; the next
//   request is still accepted and scanned, and waits at commit until the
//   result register frees up
// ----------------------------------------------------------------------------
module alert_table_priority_buzzer import atpb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  atpb_in_if.sink           req,
  atpb_out_if.source        rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // configuration registers, written in the apb access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buzzer_enable      <= RST_BUZZER_ENABLE;
      cfg.dedup_window_ms    <= RST_DEDUP_WINDOW;
      cfg.repeat_interval_ms <= RST_REPEAT_INTERVAL;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_BUZZER_ENABLE:   cfg.buzzer_enable      <= pwdata[0];
        REG_DEDUP_WINDOW:    cfg.dedup_window_ms    <= pwdata[15:0];
        REG_REPEAT_INTERVAL: cfg.repeat_interval_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_BUZZER_ENABLE:   prdata = {31'd0, cfg.buzzer_enable};
      REG_DEDUP_WINDOW:    prdata = {16'd0, cfg.dedup_window_ms};
      REG_REPEAT_INTERVAL: prdata = {16'd0, cfg.repeat_interval_ms};
      default:             prdata = 32'd0;
    endcase
  end

  assign pready    = 1'b1;
  assign req.ready = in_ready;

  // sequencer
  atpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // table, scan and result register
  atpb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg         (cfg),
    .mode        (req.mode),
    .alert_type  (req.alert_type),
    .entry_index (req.entry_index),
    .now_ms      (req.now_ms),
    .rsp         (rsp)
  );

endmodule

@@ tb/alert_table_priority_buzzer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alert_table_priority_buzzer_tb
// drives command beats (add, acknowledge, clear, tick, read and the spare
// modes) into the alert table, keeps its own copy of the table and buzzer
// timing, and checks every result beat field by field against it; register
// settings change between tests while the block is idle
// ----------------------------------------------------------------------------
module alert_table_priority_buzzer_tb;
  import atpb_pkg::*;

  localparam int RUN_CYCLE_LIMIT = 400000;
  localparam int SLOTS           = TABLE_DEPTH;

  // spare mode codes, no effect on the table
  localparam logic [2:0] MODE_SPARE_5 = 3'd5;
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic        tone_start;
    logic [10:0] tone_freq_hz;
    logic [8:0]  tone_len_ms;
    logic [2:0]  tone_pulses;
    logic        any_active;
    logic [3:0]  stored_count;
    logic [2:0]  read_type;
    logic [31:0] read_time;
    logic        read_acked;
  } alert_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  atpb_in_if  req_ch ();
  atpb_out_if rsp_ch ();

  alert_table_priority_buzzer DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // shadow of the alert table and buzzer timing
  logic [2:0]  tbl_kind  [SLOTS];
  logic [31:0] tbl_stamp [SLOTS];
  logic        tbl_acked [SLOTS];
  int unsigned tbl_used;
  logic [31:0] last_beep_ms;

  // shadow of the registers
  logic        cfg_enable;
  logic [15:0] cfg_window;
  logic [15:0] cfg_interval;

  alert_result_t pending_responses[$];
  logic [31:0]   now_cursor;
  int unsigned   sender_idle_pct;
  int unsigned   receiver_stall_pct;
  int unsigned   beat_no;
  int unsigned   mismatches;
  int unsigned   stray_beats;
  int unsigned   cycle_count;

  // tone pattern of one alert type; toneless types leave the fields at zero
  function automatic alert_result_t add_tone(alert_result_t r, logic [2:0] kind);
    case (kind)
      ALERT_HIGH_HR, ALERT_DESAT: begin
        r.tone_freq_hz = 11'd1000; r.tone_len_ms = 9'd200; r.tone_pulses = 3'd3;
      end
      ALERT_LOW_HR: begin
        r.tone_freq_hz = 11'd800;  r.tone_len_ms = 9'd300; r.tone_pulses = 3'd2;
      end
      ALERT_BATTERY: begin
        r.tone_freq_hz = 11'd600;  r.tone_len_ms = 9'd100; r.tone_pulses = 3'd1;
      end
      ALERT_SENSOR: begin
        r.tone_freq_hz = 11'd1200; r.tone_len_ms = 9'd150; r.tone_pulses = 3'd4;
      end
      default: ;
    endcase
    r.tone_start = (r.tone_pulses != 3'd0);
    return r;
  endfunction

  function automatic logic table_unacked();
    for (int i = 0; i < tbl_used; i++)
      if (!tbl_acked[i]) return 1'b1;
    return 1'b0;
  endfunction

  // applies one command to the shadow table and returns the beat it causes
  function automatic alert_result_t alert_response(logic [2:0] m, logic [2:0] kind,
                                                   logic [2:0] ix, logic [31:0] now);
    alert_result_t r;
    logic          dup;
    logic [2:0]    top;
    r   = '0;
    dup = 1'b0;
    top = ALERT_BLANK;
    case (m)
      MODE_ADD: begin
        // same type still inside the dedup window: dropped, ages wrap at 32 bits
        for (int i = 0; i < tbl_used; i++)
          if (tbl_kind[i] == kind && (now - tbl_stamp[i]) < {16'd0, cfg_window}) dup = 1'b1;
        if (!dup) begin
          if (tbl_used >= SLOTS) begin
            for (int i = 0; i + 1 < SLOTS; i++) begin
              tbl_kind[i]  = tbl_kind[i+1];
              tbl_stamp[i] = tbl_stamp[i+1];
              tbl_acked[i] = tbl_acked[i+1];
            end
            tbl_used = SLOTS - 1;
          end
          tbl_kind[tbl_used]  = kind;
          tbl_stamp[tbl_used] = now;
          tbl_acked[tbl_used] = 1'b0;
          tbl_used++;
          if (cfg_enable) r = add_tone(r, kind);
        end
      end
      MODE_ACK: begin
        if (ix < tbl_used) tbl_acked[ix] = 1'b1;
      end
      MODE_CLEAR: begin
        tbl_used = 0;
        for (int i = 0; i < SLOTS; i++) begin
          tbl_kind[i]  = ALERT_BLANK;
          tbl_acked[i] = 1'b0;
        end
      end
      MODE_TICK: begin
        // repeat only once strictly more than the interval has gone by
        if (cfg_enable && table_unacked() && (now - last_beep_ms) > {16'd0, cfg_interval}) begin
          for (int i = 0; i < tbl_used; i++)
            if (!tbl_acked[i] && tbl_kind[i] > top) top = tbl_kind[i];
          // a toneless winner still restarts the repeat timer
          if (top != ALERT_BLANK) begin
            r = add_tone(r, top);
            last_beep_ms = now;
          end
        end
      end
      MODE_READ: begin
        if (ix < tbl_used) begin
          r.read_type  = tbl_kind[ix];
          r.read_time  = tbl_stamp[ix];
          r.read_acked = tbl_acked[ix];
        end
      end
      default: ;
    endcase
    r.any_active   = table_unacked();
    r.stored_count = 4'(tbl_used);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result beat %0d: %s expected %0d, got %0d", beat_no, name, want, got);
    end
  endfunction

  // one command beat; the expectation is taken at the accepting edge
  task automatic send_item(logic [2:0] m, logic [2:0] kind, logic [2:0] ix,
                           logic [31:0] now);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    req_ch.valid       = 1'b1;
    req_ch.mode        = m;
    req_ch.alert_type  = kind;
    req_ch.entry_index = ix;
    req_ch.now_ms      = now;
    do @(posedge clk); while (!req_ch.ready);
    pending_responses.push_back(alert_response(m, kind, ix, now));
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_W'({reg_idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx)
      REG_BUZZER_ENABLE:   cfg_enable   = value[0];
      REG_DEDUP_WINDOW:    cfg_window   = value[15:0];
      REG_REPEAT_INTERVAL: cfg_interval = value[15:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers change only once every result is back
  task automatic program_regs(logic en, logic [15:0] window, logic [15:0] interval);
    wait_for_results();
    apb_write(REG_BUZZER_ENABLE, {31'd0, en});
    apb_write(REG_DEDUP_WINDOW, {16'd0, window});
    apb_write(REG_REPEAT_INTERVAL, {16'd0, interval});
  endtask

  // mostly adds and ticks on a moving clock so the table fills and repeats fire,
  // with acks, reads, rare clears, spare modes and time jumps mixed in
  task automatic run_alert_traffic(int count, int unsigned step_ms);
    int unsigned pick;
    logic [2:0]  m;
    logic [2:0]  kind;
    logic [2:0]  ix;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)      m = MODE_ADD;
      else if (pick < 65) m = MODE_TICK;
      else if (pick < 77) m = MODE_ACK;
      else if (pick < 92) m = MODE_READ;
      else if (pick < 95) m = MODE_CLEAR;
      else                m = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      if ($urandom_range(9) < 8) kind = 3'($urandom_range(ALERT_HIGH_HR, ALERT_SENSOR));
      else                       kind = 3'($urandom_range(ALERT_SPARE_7));
      ix   = 3'($urandom_range(SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 88)      now_cursor = now_cursor + $urandom_range(0, step_ms);
      else if (pick < 93) now_cursor = now_cursor + $urandom_range(0, 3);
      else if (pick < 97) now_cursor = $urandom();
      else                now_cursor = 32'hFFFF_FFFF - $urandom_range(0, step_ms);
      send_item(m, kind, ix, now_cursor);
    end
  endtask

  // reset register values, table walked through each special case by hand
  task automatic test_table_basics();
    sender_idle_pct    = 25;
    receiver_stall_pct = 46;
    send_item(MODE_ADD, ALERT_SENSOR, 3'd0, 32'd100);
    // one ms inside the window: dropped, then exactly at the window: kept
    send_item(MODE_ADD, ALERT_SENSOR, 3'd0, 32'd30099);
    send_item(MODE_ADD, ALERT_SENSOR, 3'd0, 32'd30100);
    // toneless types are stored like the others
    send_item(MODE_ADD, ALERT_BLANK, 3'd0, 32'd30200);
    send_item(MODE_ADD, ALERT_SPARE_6, 3'd0, 32'd30300);
    send_item(MODE_ADD, ALERT_SPARE_7, 3'd0, 32'd30400);
    send_item(MODE_ADD, ALERT_HIGH_HR, 3'd0, 32'd30500);
    send_item(MODE_ADD, ALERT_LOW_HR, 3'd0, 32'd30600);
    send_item(MODE_ADD, ALERT_DESAT, 3'd0, 32'd30700);
    // table full: oldest entry falls out
    send_item(MODE_ADD, ALERT_BATTERY, 3'd7, 32'd30800);
    send_item(MODE_READ, ALERT_BLANK, 3'd0, 32'd30800);
    send_item(MODE_READ, ALERT_SPARE_7, 3'd7, 32'd30800);
    send_item(MODE_ACK, ALERT_BLANK, 3'd0, 32'd30800);
    // toneless winner: silent but restarts the repeat timer
    send_item(MODE_TICK, ALERT_BLANK, 3'd0, 32'd30900);
    // age equal to the interval: no repeat yet
    send_item(MODE_TICK, ALERT_BLANK, 3'd0, 32'd32900);
    send_item(MODE_ACK, ALERT_BLANK, 3'd3, 32'd32900);
    send_item(MODE_ACK, ALERT_BLANK, 3'd2, 32'd32900);
    send_item(MODE_TICK, ALERT_BLANK, 3'd0, 32'd32901);
    send_item(MODE_SPARE_5, ALERT_SENSOR, 3'd1, 32'd32901);
    send_item(MODE_SPARE_7, ALERT_SENSOR, 3'd6, 32'hFFFF_FFFF);
    send_item(MODE_CLEAR, ALERT_BLANK, 3'd0, 32'd33000);
    // out-of-range read and acknowledge on an empty table
    send_item(MODE_READ, ALERT_BLANK, 3'd0, 32'd33000);
    send_item(MODE_ACK, ALERT_BLANK, 3'd7, 32'd33000);
    // age across the 32-bit wrap is small: second add dropped
    send_item(MODE_ADD, ALERT_DESAT, 3'd0, 32'hFFFF_FFFF);
    send_item(MODE_ADD, ALERT_DESAT, 3'd0, 32'h0000_0010);
    send_item(MODE_ACK, ALERT_BLANK, 3'd0, 32'h0000_0010);
    // only an unacked type-none entry is left: tick does nothing
    send_item(MODE_ADD, ALERT_BLANK, 3'd0, 32'h0000_0020);
    send_item(MODE_TICK, ALERT_BLANK, 3'd0, 32'h0010_0000);
    now_cursor = 32'h0010_0000;
  endtask

  // buzzer off, no dedup and no repeat hold-off
  task automatic test_buzzer_muted();
    program_regs(1'b0, 16'd0, 16'd0);
    run_alert_traffic(350, 500);
  endtask

  // widest window and interval, with time steps of up to 20000 ms
  task automatic test_long_windows();
    sender_idle_pct    = 46;
    receiver_stall_pct = 25;
    program_regs(1'b1, 16'hFFFF, 16'hFFFF);
    run_alert_traffic(350, 20000);
  endtask

  task automatic test_short_windows();
    program_regs(1'b1, 16'($urandom_range(1, 3000)), 16'($urandom_range(1, 1500)));
    run_alert_traffic(350, 1500);
  endtask

  // back to reset values, then no dedup and a 1 ms interval, with neither side idling
  task automatic test_full_rate();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    program_regs(RST_BUZZER_ENABLE, RST_DEDUP_WINDOW, RST_REPEAT_INTERVAL);
    run_alert_traffic(350, 3000);
    program_regs(1'b1, 16'd0, 16'd1);
    run_alert_traffic(350, 200);
  endtask

  // receiver stall pattern
  always @(negedge clk)
    rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);

  // result checker
  always @(posedge clk) begin
    alert_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_responses.size() == 0) begin
        stray_beats++;
        if (stray_beats <= 10) $display("result beat %0d with nothing expected", beat_no);
      end else begin
        want = pending_responses.pop_front();
        check_field("tone_start", 32'(want.tone_start), 32'(rsp_ch.tone_start));
        check_field("tone_freq_hz", 32'(want.tone_freq_hz), 32'(rsp_ch.tone_freq_hz));
        check_field("tone_len_ms", 32'(want.tone_len_ms), 32'(rsp_ch.tone_len_ms));
        check_field("tone_pulses", 32'(want.tone_pulses), 32'(rsp_ch.tone_pulses));
        check_field("any_active", 32'(want.any_active), 32'(rsp_ch.any_active));
        check_field("stored_count", 32'(want.stored_count), 32'(rsp_ch.stored_count));
        check_field("read_type", 32'(want.read_type), 32'(rsp_ch.read_type));
        check_field("read_time", want.read_time, rsp_ch.read_time);
        check_field("read_acked", 32'(want.read_acked), 32'(rsp_ch.read_acked));
      end
      beat_no++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_ch.valid       = 1'b0;
    req_ch.mode        = MODE_ADD;
    req_ch.alert_type  = ALERT_BLANK;
    req_ch.entry_index = 3'd0;
    req_ch.now_ms      = 32'd0;
    rsp_ch.ready       = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    beat_no            = 0;
    mismatches         = 0;
    stray_beats        = 0;
    cycle_count        = 0;
    now_cursor         = 32'd0;
    // shadow state after reset
    for (int i = 0; i < SLOTS; i++) begin
      tbl_kind[i]  = ALERT_BLANK;
      tbl_stamp[i] = 32'd0;
      tbl_acked[i] = 1'b0;
    end
    tbl_used     = 0;
    last_beep_ms = 32'd0;
    cfg_enable   = RST_BUZZER_ENABLE;
    cfg_window   = RST_DEDUP_WINDOW;
    cfg_interval = RST_REPEAT_INTERVAL;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_table_basics();
    test_buzzer_muted();
    test_long_windows();
    test_short_windows();
    test_full_rate();

    // drain, then give the block room to show any extra beat
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && stray_beats == 0 && pending_responses.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/atpb_pkg.sv
hw/rtl/atpb_if.sv
hw/rtl/atpb_ctrl.sv
hw/rtl/atpb_datapath.sv
hw/rtl/alert_table_priority_buzzer.sv
tb/alert_table_priority_buzzer_tb.sv
